FILE: sv/ubms_pkg.sv
// Shared types and constants for the UNIBUS bus master sequencer.
// No dependencies.
package ubms_pkg;

  localparam int DATA_BITS  = 16;
  localparam int VEC_BITS   = 9;
  localparam int BLEN_BITS  = 2;
  localparam int LEVEL_BITS = 3;
  localparam int CFG_BITS   = 9;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [VEC_BITS-1:0]   VEC_RESET   = 9'o160;
  localparam logic [BLEN_BITS-1:0]  BLEN_RESET  = 2'd1;
  localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = 3'd5;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_VECTOR = 2'd0,
    CFG_BLEN   = 2'd1,
    CFG_LEVEL  = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_DMA  = 2'd1,
    REQ_INTR = 2'd2,
    REQ_RSVD = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    EV_IDLE  = 3'd0,
    EV_BUSY  = 3'd1,
    EV_TAKEN = 3'd2,
    EV_READ  = 3'd3,
    EV_DONE  = 3'd4
  } ev_t;

  typedef struct packed {
    logic npr;
    logic br;
    logic sack;
    logic bbsy;
    logic intr;
    logic den;
    logic blocked;
    logic mode;
  } drv_t;

endpackage

FILE: sv/ubms_core.sv
// Arbitration and data-cycle sequencer state; one phase step per beat.
// Depends on ubms_pkg.
module ubms_core #(
  parameter int ADDRESS_BITS = 18,
  parameter int COUNT_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  logic [1:0]                        req_type,
  input  logic                              dma_is_write,
  input  logic [ADDRESS_BITS-1:0]           start_address,
  input  logic [COUNT_BITS-1:0]             word_count,
  input  logic [ubms_pkg::DATA_BITS-1:0]    write_word,
  input  logic                              grant_npg,
  input  logic                              grant_bg,
  input  logic                              bus_busy,
  input  logic                              slave_sync,
  input  logic                              cycle_idle,
  input  logic [ubms_pkg::DATA_BITS-1:0]    read_word,
  input  logic [ubms_pkg::VEC_BITS-1:0]     vector,
  input  logic [ubms_pkg::BLEN_BITS-1:0]    blen,
  output ubms_pkg::drv_t                    drv,
  output logic [ADDRESS_BITS-1:0]           bus_address,
  output logic [ubms_pkg::DATA_BITS-1:0]    data_word,
  output ubms_pkg::ev_t                     ev
);

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_D_GRANT  = 4'd1,
    PH_D_GDROP  = 4'd2,
    PH_D_BUS    = 4'd3,
    PH_D_XFER   = 4'd4,
    PH_D_REL    = 4'd5,
    PH_I_GRANT  = 4'd6,
    PH_I_GDROP  = 4'd7,
    PH_I_BUS    = 4'd8,
    PH_I_NOSSYN = 4'd9,
    PH_I_DRIVE  = 4'd10
  } phase_t;

  phase_t                           phase_r, phase_nxt;
  logic                             is_wr_r, is_wr_nxt;
  logic [ADDRESS_BITS-1:0]          addr_r, addr_nxt;
  logic [COUNT_BITS-1:0]            left_r, left_nxt;
  logic [ubms_pkg::BLEN_BITS-1:0]   bidx_r, bidx_nxt;
  logic [ubms_pkg::DATA_BITS-1:0]   hold_r, hold_nxt;
  logic [ubms_pkg::BLEN_BITS-1:0]   blen_eff;

  assign blen_eff = (blen == '0) ? ubms_pkg::BLEN_BITS'(1) : blen;

  always_comb begin
    phase_nxt = phase_r;
    is_wr_nxt = is_wr_r;
    addr_nxt  = addr_r;
    left_nxt  = left_r;
    bidx_nxt  = bidx_r;
    hold_nxt  = hold_r;
    ev        = ubms_pkg::EV_BUSY;
    case (phase_r)
      PH_IDLE: begin
        ev = ubms_pkg::EV_IDLE;
        if (req_type == ubms_pkg::REQ_DMA) begin
          is_wr_nxt = dma_is_write;
          addr_nxt  = start_address;
          left_nxt  = word_count;
          bidx_nxt  = '0;
          if (word_count == '0) begin
            ev = ubms_pkg::EV_DONE;
          end else begin
            phase_nxt = PH_D_GRANT;
            ev        = ubms_pkg::EV_BUSY;
          end
        end else if (req_type == ubms_pkg::REQ_INTR) begin
          phase_nxt = PH_I_GRANT;
          ev        = ubms_pkg::EV_BUSY;
        end
      end
      PH_D_GRANT: if (grant_npg) phase_nxt = PH_D_GDROP;
      PH_D_GDROP: if (!grant_npg) phase_nxt = PH_D_BUS;
      PH_D_BUS: begin
        if (!bus_busy) begin
          phase_nxt = PH_D_XFER;
          bidx_nxt  = '0;
        end
      end
      PH_D_XFER: begin
        if (is_wr_r) hold_nxt = write_word;
        if (cycle_idle) begin
          if (is_wr_r) begin
            ev = ubms_pkg::EV_TAKEN;
          end else begin
            hold_nxt = read_word;
            ev       = ubms_pkg::EV_READ;
          end
          addr_nxt = addr_r + ADDRESS_BITS'(2);
          left_nxt = left_r - COUNT_BITS'(1);
          bidx_nxt = bidx_r + ubms_pkg::BLEN_BITS'(1);
          if (bidx_nxt >= blen_eff || bidx_nxt == '0 || left_nxt == '0) begin
            phase_nxt = PH_D_REL;
          end
        end
      end
      PH_D_REL: begin
        bidx_nxt = '0;
        if (left_r == '0) begin
          phase_nxt = PH_IDLE;
          ev        = ubms_pkg::EV_DONE;
        end else begin
          phase_nxt = PH_D_GRANT;
        end
      end
      PH_I_GRANT: if (grant_bg) phase_nxt = PH_I_GDROP;
      PH_I_GDROP: if (!grant_bg) phase_nxt = PH_I_BUS;
      PH_I_BUS: begin
        if (!bus_busy) begin
          hold_nxt  = {{(ubms_pkg::DATA_BITS-ubms_pkg::VEC_BITS){1'b0}}, vector};
          phase_nxt = PH_I_NOSSYN;
        end
      end
      PH_I_NOSSYN: if (!slave_sync) phase_nxt = PH_I_DRIVE;
      PH_I_DRIVE: begin
        if (slave_sync) begin
          phase_nxt = PH_IDLE;
          ev        = ubms_pkg::EV_DONE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        ev        = ubms_pkg::EV_IDLE;
      end
    endcase
  end

  // bus levels follow the phase after this beat's update
  always_comb begin
    drv.npr  = (phase_nxt == PH_D_GRANT);
    drv.br   = (phase_nxt == PH_I_GRANT);
    drv.sack = (phase_nxt == PH_D_GDROP) || (phase_nxt == PH_D_BUS) ||
               (phase_nxt == PH_D_XFER) || (phase_nxt == PH_I_GDROP) ||
               (phase_nxt == PH_I_BUS) || (phase_nxt == PH_I_NOSSYN);
    drv.bbsy = (phase_nxt == PH_D_XFER) || (phase_nxt == PH_I_NOSSYN) ||
               (phase_nxt == PH_I_DRIVE);
    drv.intr = (phase_nxt == PH_I_DRIVE);
    drv.den  = ((phase_nxt == PH_D_XFER) && is_wr_nxt) ||
               (phase_nxt == PH_I_NOSSYN) || (phase_nxt == PH_I_DRIVE);
    drv.blocked = (phase_nxt == PH_D_GRANT) || (phase_nxt == PH_D_GDROP) ||
                  (phase_nxt == PH_D_BUS) || (phase_nxt == PH_D_XFER) ||
                  (phase_nxt == PH_I_GRANT) || (phase_nxt == PH_I_GDROP) ||
                  (phase_nxt == PH_I_BUS) || (phase_nxt == PH_I_NOSSYN) ||
                  (phase_nxt == PH_I_DRIVE);
    drv.mode = (phase_nxt == PH_D_XFER);
  end

  assign bus_address = addr_nxt;
  assign data_word   = hold_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      is_wr_r <= 1'b0;
      addr_r  <= '0;
      left_r  <= '0;
      bidx_r  <= '0;
      hold_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      is_wr_r <= is_wr_nxt;
      addr_r  <= addr_nxt;
      left_r  <= left_nxt;
      bidx_r  <= bidx_nxt;
      hold_r  <= hold_nxt;
    end
  end

endmodule

FILE: sv/unibus_bus_master_sequencer.sv
// UNIBUS NPR/BR bus master sequencer: input register, sequencer step, result register.
// An accepted beat passes the input register, then the result register; one beat per cycle
// sustained while out_stall is low, the sequencer step being combinational between the two.
// Synchronous active-low reset returns the sequencer to idle with address, count and
// data cleared and the config registers at vector 0160, burst 1, level 5.
// Depends on ubms_pkg and ubms_core.
module unibus_bus_master_sequencer #(
  parameter int ADDRESS_BITS = 18,
  parameter int COUNT_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [ubms_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ubms_pkg::CFG_BITS-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_req_type,
  input  logic                              in_dma_is_write,
  input  logic [ADDRESS_BITS-1:0]           in_start_address,
  input  logic [COUNT_BITS-1:0]             in_word_count,
  input  logic [ubms_pkg::DATA_BITS-1:0]    in_write_word,
  input  logic                              in_grant_npg,
  input  logic                              in_grant_bg,
  input  logic                              in_bus_busy,
  input  logic                              in_slave_sync,
  input  logic                              in_cycle_idle,
  input  logic [ubms_pkg::DATA_BITS-1:0]    in_read_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_drive_npr,
  output logic                              out_drive_br,
  output logic                              out_drive_sack,
  output logic                              out_drive_bbsy,
  output logic                              out_drive_intr,
  output logic                              out_data_drive_enable,
  output logic                              out_grant_blocked,
  output logic                              out_cycle_mode,
  output logic [ADDRESS_BITS-1:0]           out_bus_address,
  output logic [ubms_pkg::DATA_BITS-1:0]    out_data_word,
  output logic [2:0]                        out_event_code
);

  logic [ubms_pkg::VEC_BITS-1:0]    vec_r;
  logic [ubms_pkg::BLEN_BITS-1:0]   blen_r;
  logic [ubms_pkg::LEVEL_BITS-1:0]  level_r;

  logic                             ivld_r;
  logic [1:0]                       req_r;
  logic                             wr_r;
  logic [ADDRESS_BITS-1:0]          saddr_r;
  logic [COUNT_BITS-1:0]            cnt_r;
  logic [ubms_pkg::DATA_BITS-1:0]   wword_r;
  logic                             npg_r, bg_r, bbsy_r, ssyn_r, cidle_r;
  logic [ubms_pkg::DATA_BITS-1:0]   rword_r;

  logic                             ovld_r;
  ubms_pkg::drv_t                   drv_r, drv_c;
  logic [ADDRESS_BITS-1:0]          addr_r, addr_c;
  logic [ubms_pkg::DATA_BITS-1:0]   data_r, data_c;
  ubms_pkg::ev_t                    ev_r, ev_c;

  logic adv;
  logic in_take;

  assign adv      = ivld_r && (!ovld_r || !out_stall);
  assign in_stall = ivld_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_r   <= ubms_pkg::VEC_RESET;
      blen_r  <= ubms_pkg::BLEN_RESET;
      level_r <= ubms_pkg::LEVEL_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ubms_pkg::CFG_VECTOR: vec_r   <= cfg_data[ubms_pkg::VEC_BITS-1:0];
        ubms_pkg::CFG_BLEN:   blen_r  <= cfg_data[ubms_pkg::BLEN_BITS-1:0];
        ubms_pkg::CFG_LEVEL:  level_r <= cfg_data[ubms_pkg::LEVEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r <= 1'b0;
    end else if (in_take) begin
      ivld_r <= 1'b1;
    end else if (adv) begin
      ivld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r   <= in_req_type;
      wr_r    <= in_dma_is_write;
      saddr_r <= in_start_address;
      cnt_r   <= in_word_count;
      wword_r <= in_write_word;
      npg_r   <= in_grant_npg;
      bg_r    <= in_grant_bg;
      bbsy_r  <= in_bus_busy;
      ssyn_r  <= in_slave_sync;
      cidle_r <= in_cycle_idle;
      rword_r <= in_read_word;
    end
  end

  ubms_core #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (adv),
    .req_type      (req_r),
    .dma_is_write  (wr_r),
    .start_address (saddr_r),
    .word_count    (cnt_r),
    .write_word    (wword_r),
    .grant_npg     (npg_r),
    .grant_bg      (bg_r),
    .bus_busy      (bbsy_r),
    .slave_sync    (ssyn_r),
    .cycle_idle    (cidle_r),
    .read_word     (rword_r),
    .vector        (vec_r),
    .blen          (blen_r),
    .drv           (drv_c),
    .bus_address   (addr_c),
    .data_word     (data_c),
    .ev            (ev_c)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (adv) begin
      ovld_r <= 1'b1;
    end else if (!out_stall) begin
      ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drv_r  <= drv_c;
      addr_r <= addr_c;
      data_r <= data_c;
      ev_r   <= ev_c;
    end
  end

  assign out_valid             = ovld_r;
  assign out_drive_npr         = drv_r.npr;
  assign out_drive_br          = drv_r.br;
  assign out_drive_sack        = drv_r.sack;
  assign out_drive_bbsy        = drv_r.bbsy;
  assign out_drive_intr        = drv_r.intr;
  assign out_data_drive_enable = drv_r.den;
  assign out_grant_blocked     = drv_r.blocked;
  assign out_cycle_mode        = drv_r.mode;
  assign out_bus_address       = addr_r;
  assign out_data_word         = data_r;
  assign out_event_code        = ev_r;

  a_req_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_drive_npr && out_drive_br))
    else $error("NPR and BR raised together");

  a_done_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_code == ubms_pkg::EV_DONE |-> !out_drive_bbsy && !out_grant_blocked)
    else $error("done beat while still holding the bus");

  a_master_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_drive_bbsy || out_cycle_mode) |-> out_grant_blocked)
    else $error("bus master with grant pass-through open");

  a_level_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en && cfg_index == ubms_pkg::CFG_LEVEL
      |=> level_r == $past(cfg_data[ubms_pkg::LEVEL_BITS-1:0]))
    else $error("interrupt level write lost");

endmodule
